>>> rtl/mtdd_pkg.sv
`timescale 1ns / 1ps

package mtdd_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_WINDOW = 3'd0;
    localparam logic [2:0] REG_STEP0  = 3'd1;
    localparam logic [2:0] REG_STEP1  = 3'd2;
    localparam logic [2:0] REG_STEP2  = 3'd3;
    localparam logic [2:0] REG_STEP3  = 3'd4;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int WIN_W         = 11;
    localparam int PHASE_W       = 32;
    localparam int NUM_STEP_REGS = 4;

    localparam logic [WIN_W-1:0] WIN_RESET = 11'd800;
    localparam logic [PHASE_W-1:0] STEP_RESET [NUM_STEP_REGS] = '{
        32'd697932186, 32'd751619277, 32'd805306368, 32'd858993459
    };

    // Result field widths
    localparam int SUM_OUT_W    = 26;
    localparam int DIFF_OUT_W   = 53;
    localparam int OUT_FIELDS_W = 2 * SUM_OUT_W + 2 * DIFF_OUT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Carrier table: 1024 entries of {sin, cos}, 16 bits each
    localparam int CARRIER_W     = 16;
    localparam int CARRIER_AW    = 10;
    localparam int CARRIER_DEPTH = 1 << CARRIER_AW;
    localparam int CORDIC_STEPS  = 16;
    localparam longint CORDIC_X0   = 5093852;
    localparam longint CARRIER_MAX = 32767;
    localparam longint ATAN_UNITS [CORDIC_STEPS] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    localparam int DEROT_SHIFT = 15;
    localparam int ROUND_HALF  = 1 << (DEROT_SHIFT - 1);

    typedef logic [2*CARRIER_W-1:0] carrier_rom_t [CARRIER_DEPTH];

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ctl_state_t;

    // Pipeline steps after a request is taken
    localparam logic [2:0] STG_MUL  = 3'd0;
    localparam logic [2:0] STG_RND  = 3'd1;
    localparam logic [2:0] STG_ACC  = 3'd2;
    localparam logic [2:0] STG_DMUL = 3'd3;
    localparam logic [2:0] STG_DADD = 3'd4;

    typedef struct packed {
        logic start;
        logic mul;
        logic rnd;
        logic acc;
        logic dmul;
        logic dadd;
        logic clr;
    } lane_ctrl_t;

    function automatic carrier_rom_t build_carrier_rom();
        carrier_rom_t rom;
        logic [31:0]  a;
        logic         neg;
        longint       x;
        longint       y;
        longint       z;
        longint       dx;
        longint       dy;
        longint       xc;
        longint       yc;
        for (int k = 0; k < CARRIER_DEPTH; k++) begin
            a   = 32'(k) << (PHASE_W - CARRIER_AW);
            neg = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
            if (neg)
                a = a - 32'h8000_0000;
            z = longint'($signed(a));
            x = CORDIC_X0;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_UNITS[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_UNITS[i];
                end
            end
            xc = (x + 128) >>> 8;
            yc = (y + 128) >>> 8;
            xc = (xc > CARRIER_MAX) ? CARRIER_MAX : ((xc < -CARRIER_MAX) ? -CARRIER_MAX : xc);
            yc = (yc > CARRIER_MAX) ? CARRIER_MAX : ((yc < -CARRIER_MAX) ? -CARRIER_MAX : yc);
            if (neg) begin
                xc = -xc;
                yc = -yc;
            end
            rom[k] = {yc[CARRIER_W-1:0], xc[CARRIER_W-1:0]};
        end
        return rom;
    endfunction

    localparam carrier_rom_t CARRIER_ROM = build_carrier_rom();

endpackage

>>> rtl/mtdd_lane.sv
`timescale 1ns / 1ps

module mtdd_lane
    import mtdd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_WINDOW   = 1024,
    localparam int PW   = $clog2(MAX_WINDOW),
    localparam int SUMW = SAMPLE_WIDTH + PW,
    localparam int DW   = 2 * SUMW + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lane_ctrl_t                     ctrl,
    input  logic [PW-1:0]                  addr,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    input  logic [PHASE_W-1:0]             phase_step,
    output logic signed [SUMW-1:0]         sum_re,
    output logic signed [SUMW-1:0]         sum_im,
    output logic signed [DW-1:0]           diff_re,
    output logic signed [DW-1:0]           diff_im
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int PRW = SW + CARRIER_W + 1;
    localparam logic signed [PRW-1:0] SMAX = PRW'((1 <<< (SW - 1)) - 1);
    localparam logic signed [PRW-1:0] SMIN = -PRW'(1 <<< (SW - 1));

    logic [PHASE_W-1:0]              phase_reg;
    logic [PHASE_W-1:0]              phase_next;
    logic [2*CARRIER_W-1:0]          cs_reg;
    logic signed [SW-1:0]            a_reg;
    logic signed [SW-1:0]            b_reg;
    logic signed [SW+CARRIER_W-1:0]  ac_reg;
    logic signed [SW+CARRIER_W-1:0]  bs_reg;
    logic signed [SW+CARRIER_W-1:0]  bc_reg;
    logic signed [SW+CARRIER_W-1:0]  as_reg;
    logic signed [SW-1:0]            dr_reg;
    logic signed [SW-1:0]            di_reg;
    logic signed [SW-1:0]            dr_next;
    logic signed [SW-1:0]            di_next;
    logic signed [PRW-1:0]           re_sh;
    logic signed [PRW-1:0]           im_sh;
    logic signed [CARRIER_W-1:0]     cos_s;
    logic signed [CARRIER_W-1:0]     sin_s;

    logic [2*SW-1:0]                 drot_mem [MAX_WINDOW];
    logic [2*SUMW-1:0]               dly_mem  [MAX_WINDOW];
    logic [2*SW-1:0]                 drot_rd_reg;
    logic [2*SUMW-1:0]               dly_rd_reg;

    logic signed [SUMW-1:0]          sr_reg;
    logic signed [SUMW-1:0]          si_reg;
    logic signed [SUMW-1:0]          sr_next;
    logic signed [SUMW-1:0]          si_next;
    logic signed [SUMW-1:0]          orr;
    logic signed [SUMW-1:0]          oim;
    logic signed [2*SUMW-1:0]        p_rr_reg;
    logic signed [2*SUMW-1:0]        p_ii_reg;
    logic signed [2*SUMW-1:0]        p_ir_reg;
    logic signed [2*SUMW-1:0]        p_ri_reg;
    logic signed [DW-1:0]            dre_reg;
    logic signed [DW-1:0]            dim_reg;

    assign cos_s = $signed(cs_reg[CARRIER_W-1:0]);
    assign sin_s = $signed(cs_reg[2*CARRIER_W-1:CARRIER_W]);
    assign orr   = $signed(dly_rd_reg[SUMW-1:0]);
    assign oim   = $signed(dly_rd_reg[2*SUMW-1:SUMW]);

    always_comb
    begin
        phase_next = phase_reg + phase_step;
        re_sh = (PRW'(ac_reg) + PRW'(bs_reg) + PRW'(ROUND_HALF)) >>> DEROT_SHIFT;
        im_sh = (PRW'(bc_reg) - PRW'(as_reg) + PRW'(ROUND_HALF)) >>> DEROT_SHIFT;
        if (re_sh > SMAX)
            dr_next = SW'(SMAX);
        else if (re_sh < SMIN)
            dr_next = SW'(SMIN);
        else
            dr_next = SW'(re_sh);
        if (im_sh > SMAX)
            di_next = SW'(SMAX);
        else if (im_sh < SMIN)
            di_next = SW'(SMIN);
        else
            di_next = SW'(im_sh);
        // ring holds the sample leaving the window
        sr_next = sr_reg + SUMW'(dr_reg) - SUMW'($signed(drot_rd_reg[SW-1:0]));
        si_next = si_reg + SUMW'(di_reg) - SUMW'($signed(drot_rd_reg[2*SW-1:SW]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= '0;
            sr_reg    <= '0;
            si_reg    <= '0;
        end else begin
            if (ctrl.start)
                phase_reg <= phase_next;
            if (ctrl.acc) begin
                sr_reg <= sr_next;
                si_reg <= si_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start) begin
            cs_reg <= CARRIER_ROM[phase_reg[PHASE_W-1:PHASE_W-CARRIER_AW]];
            a_reg  <= sample_re;
            b_reg  <= sample_im;
        end
        if (ctrl.mul) begin
            ac_reg <= a_reg * cos_s;
            bs_reg <= b_reg * sin_s;
            bc_reg <= b_reg * cos_s;
            as_reg <= a_reg * sin_s;
        end
        if (ctrl.rnd) begin
            dr_reg <= dr_next;
            di_reg <= di_next;
        end
        if (ctrl.dmul) begin
            p_rr_reg <= sr_reg * orr;
            p_ii_reg <= si_reg * oim;
            p_ir_reg <= si_reg * orr;
            p_ri_reg <= sr_reg * oim;
        end
        if (ctrl.dadd) begin
            dre_reg <= DW'(p_rr_reg) + DW'(p_ii_reg);
            dim_reg <= DW'(p_ir_reg) - DW'(p_ri_reg);
        end
    end

    // Rings: one read on request, one write per sample; zero them on the clear sweep
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
            drot_rd_reg <= drot_mem[addr];
        if (ctrl.clr)
            drot_mem[addr] <= '0;
        else if (ctrl.acc)
            drot_mem[addr] <= {di_reg, dr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
            dly_rd_reg <= dly_mem[addr];
        if (ctrl.clr)
            dly_mem[addr] <= '0;
        else if (ctrl.dmul)
            dly_mem[addr] <= {si_reg, sr_reg};
    end

    assign sum_re  = sr_reg;
    assign sum_im  = si_reg;
    assign diff_re = dre_reg;
    assign diff_im = dim_reg;

endmodule

>>> rtl/mtdd_merge.sv
`timescale 1ns / 1ps

module mtdd_merge
    import mtdd_pkg::*;
#(
    parameter int TONE_COUNT = 4,
    parameter int SUMW       = 26,
    parameter int DW         = 53,
    localparam int IDX_W     = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [TONE_COUNT-1:0][SUMW-1:0]      sum_re,
    input  logic [TONE_COUNT-1:0][SUMW-1:0]      sum_im,
    input  logic [TONE_COUNT-1:0][DW-1:0]        diff_re,
    input  logic [TONE_COUNT-1:0][DW-1:0]        diff_im,
    output logic                                 busy,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [OUT_DATA_W-1:0]                m_tdata,
    output logic [IDX_W-1:0]                     m_tuser,
    output logic                                 m_tlast
);

    logic [OUT_FIELDS_W-1:0] res_reg [TONE_COUNT];
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    at_last;

    assign at_last = (idx_reg == IDX_W'(TONE_COUNT - 1));

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg && m_tready) begin
            idx_next  = idx_reg + 1'b1;
            if (at_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int t = 0; t < TONE_COUNT; t++)
                res_reg[t] <= {DIFF_OUT_W'($signed(diff_im[t])),
                               DIFF_OUT_W'($signed(diff_re[t])),
                               SUM_OUT_W'($signed(sum_im[t])),
                               SUM_OUT_W'($signed(sum_re[t]))};
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tdata  = OUT_DATA_W'(res_reg[idx_reg]);
    assign m_tuser  = idx_reg;
    assign m_tlast  = at_last;

endmodule

>>> rtl/multitone_mix_integrate_diff_detect_core.sv
`timescale 1ns / 1ps

// Four-tone carrier correlator with differential phase detection. Each request
// carries one complex sample per tone; one lane per tone derotates it by its
// local oscillator, keeps a moving sum over window_length samples and multiplies
// it by the conjugate of the sum one window earlier. Results leave one per tone,
// tone 0 first, with tlast on the final tone. A sample passes through the lane
// pipeline steps in order (ring read, derotation multiply, round, accumulate,
// delay multiply, add, hand-off); the hand-off waits until the output buffer has
// drained, and a new request is not taken until the hand-off is done. After
// reset the rings are zeroed in a sweep over all MAX_WINDOW entries before the
// first request is taken.

module multitone_mix_integrate_diff_detect_core
    import mtdd_pkg::*;
#(
    parameter int TONE_COUNT   = 4,
    parameter int MAX_WINDOW   = 1024,
    parameter int SAMPLE_WIDTH = 16,
    localparam int PW    = $clog2(MAX_WINDOW),
    localparam int SUMW  = SAMPLE_WIDTH + PW,
    localparam int DW    = 2 * SUMW + 1,
    localparam int IN_W  = ((2 * TONE_COUNT * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int IDX_W = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // tone0_re, tone0_im, tone1_re, tone1_im, ... from bit 0 up
    input  logic [IN_W-1:0]        s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sum_re, sum_im, diff_re, diff_im from bit 0 up
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // tone_index
    output logic [IDX_W-1:0]       m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = (PW + 1 > WIN_W) ? PW + 1 : WIN_W;

    ctl_state_t         state_reg;
    ctl_state_t         state_next;
    logic [2:0]         stage_reg;
    logic [2:0]         stage_next;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_next;
    logic [PW-1:0]      clr_reg;
    logic [PW-1:0]      clr_next;
    logic [WIN_W-1:0]   win_reg;
    logic [PHASE_W-1:0] step_reg [NUM_STEP_REGS];
    logic [CW-1:0]      win_eff;
    logic [PW-1:0]      ring_addr;
    logic               accept;
    logic               merge_busy;
    logic               load;
    lane_ctrl_t         ctrl;

    logic [TONE_COUNT-1:0][SUMW-1:0] lane_sum_re;
    logic [TONE_COUNT-1:0][SUMW-1:0] lane_sum_im;
    logic [TONE_COUNT-1:0][DW-1:0]   lane_diff_re;
    logic [TONE_COUNT-1:0][DW-1:0]   lane_diff_im;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == PW'(MAX_WINDOW - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_RUN;
            ST_RUN:
                if (stage_reg == STG_DADD)
                    state_next = ST_HOLD;
            ST_HOLD:
                if (!merge_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        load       = 1'b0;
        ctrl       = '0;
        case (state_reg)
            ST_CLEAR:
                ctrl.clr = 1'b1;
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctrl.start = s_tvalid;
            end
            ST_RUN:
            begin
                ctrl.mul  = (stage_reg == STG_MUL);
                ctrl.rnd  = (stage_reg == STG_RND);
                ctrl.acc  = (stage_reg == STG_ACC);
                ctrl.dmul = (stage_reg == STG_DMUL);
                ctrl.dadd = (stage_reg == STG_DADD);
            end
            ST_HOLD:
                load = !merge_busy;
            default:
                ctrl = '0;
        endcase
    end

    always_comb
    begin
        if (win_reg == '0)
            win_eff = CW'(1);
        else if (CW'(win_reg) > CW'(MAX_WINDOW))
            win_eff = CW'(MAX_WINDOW);
        else
            win_eff = CW'(win_reg);

        stage_next = (state_reg == ST_RUN) ? stage_reg + 3'd1 : STG_MUL;
        clr_next   = (state_reg == ST_CLEAR) ? clr_reg + 1'b1 : clr_reg;

        pos_next = pos_reg;
        if (ctrl.dadd)
            pos_next = (CW'(pos_reg) + CW'(1) >= win_eff) ? '0 : pos_reg + 1'b1;

        ring_addr = (state_reg == ST_CLEAR) ? clr_reg : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            stage_reg <= STG_MUL;
            pos_reg   <= '0;
            clr_reg   <= '0;
            win_reg   <= WIN_RESET;
            for (int i = 0; i < NUM_STEP_REGS; i++)
                step_reg[i] <= STEP_RESET[i];
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            pos_reg   <= pos_next;
            clr_reg   <= clr_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_WINDOW: win_reg     <= cfg_data[WIN_W-1:0];
                    REG_STEP0:  step_reg[0] <= cfg_data;
                    REG_STEP1:  step_reg[1] <= cfg_data;
                    REG_STEP2:  step_reg[2] <= cfg_data;
                    REG_STEP3:  step_reg[3] <= cfg_data;
                    default:    win_reg     <= win_reg;
                endcase
            end
        end
    end

    for (genvar t = 0; t < TONE_COUNT; t++) begin : g_lane
        mtdd_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .MAX_WINDOW   (MAX_WINDOW)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .addr       (ring_addr),
            .sample_re  ($signed(s_tdata[2*t*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .sample_im  ($signed(s_tdata[(2*t+1)*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .phase_step (step_reg[t % NUM_STEP_REGS]),
            .sum_re     (lane_sum_re[t]),
            .sum_im     (lane_sum_im[t]),
            .diff_re    (lane_diff_re[t]),
            .diff_im    (lane_diff_im[t])
        );
    end

    mtdd_merge #(
        .TONE_COUNT (TONE_COUNT),
        .SUMW       (SUMW),
        .DW         (DW)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .sum_re   (lane_sum_re),
        .sum_im   (lane_sum_im),
        .diff_re  (lane_diff_re),
        .diff_im  (lane_diff_im),
        .busy     (merge_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !m_tvalid)
        else $error("result buffer loaded while still draining");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while a sample is in the lanes");

    a_last_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == IDX_W'(TONE_COUNT - 1)))
        else $error("tlast not on the final tone");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!m_tvalid && !s_tready))
        else $error("traffic during ring clear");

    a_pos_moves_once: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> $past(ctrl.dadd))
        else $error("ring position moved outside the last step");
`endif

endmodule
